@@ rtl/nbrh_pkg.sv @@
// ----------------------------------------------------------------------------
// nbrh_pkg
// types and constants shared by the numbered block ring history unit
// ----------------------------------------------------------------------------
package nbrh_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int TEXT_LIMIT    = 64;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_FIND  = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_AMBIGUOUS = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] block_number;
    logic [15:0] text_handle;
    logic [9:0]  text_length;
    logic [31:0] range_first;
    logic [31:0] range_last;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] out_block_number;
    logic [15:0] out_text_handle;
    logic        last_item;
    logic        evicted_flag;
    logic [4:0]  visited_count;
  } out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      number;
    logic [15:0]      handle;
  } wr_t;

endpackage

@@ rtl/nbrh_store.sv @@
// ----------------------------------------------------------------------------
// nbrh_store
// entry register file: block numbers and text handles, one write, one read
// ----------------------------------------------------------------------------
module nbrh_store
  import nbrh_pkg::*;
(
  input  logic             clk,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_number,
  output logic [15:0]      rd_handle
);

  logic [31:0] number_r [HISTORY_DEPTH];
  logic [15:0] handle_r [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      number_r[wr.addr] <= wr.number;
      handle_r[wr.addr] <= wr.handle;
    end
  end

  assign rd_number = number_r[rd_addr];
  assign rd_handle = handle_r[rd_addr];

endmodule

@@ rtl/numbered_block_ring_history_unit.sv @@
// ----------------------------------------------------------------------------
// numbered_block_ring_history_unit
// ring of numbered entries with add, find, range visit and clear
// ----------------------------------------------------------------------------
// add, clear and range with Q below P: result in the cycle after the request
// find: one slot per cycle through one compare
// range: a scan for P and then Q, a duplicate check over the entries from
// P to Q, then one result a cycle
// all steps share the single comparator and store read port
// reset (synchronous, rst_n low) empties the ring; stores need no clearing
// results are strobed for one cycle; the receiver cannot stall
module numbered_block_ring_history_unit
  import nbrh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_SCAN, S_DUPA, S_DUPB, S_EMIT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] wp_r;
  logic [CNT_W-1:0] count_r;
  logic             evict_r;
  logic [CNT_W-1:0] idx_r, a_r, b_r, start_r, end_r;
  logic             have_start_r;
  logic [31:0]      key_r, p_r, q_r, num_a_r;
  logic             out_valid_r;
  out_t             out_r;
  logic             out_valid_nxt;
  out_t             out_nxt;

  wr_t              wr;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_number;
  logic [15:0]      rd_handle;
  logic             full;
  logic [CNT_W-1:0] pos;
  logic [CNT_W:0]   wsum;
  logic [31:0]      cmp_b;
  logic             eq;
  logic             accept;
  logic [CNT_W-1:0] vcnt;

  assign full   = (count_r == CNT_W'(HISTORY_DEPTH));
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // position to slot: oldest entry sits at the write pointer once full
  always_comb begin
    case (state_r)
      S_DUPA:  pos = a_r;
      S_DUPB:  pos = b_r;
      default: pos = idx_r;
    endcase
    wsum = {1'b0, pos} + (full ? (CNT_W + 1)'(wp_r) : '0);
    if (wsum >= (CNT_W + 1)'(HISTORY_DEPTH)) begin
      wsum = wsum - (CNT_W + 1)'(HISTORY_DEPTH);
    end
    rd_addr = (state_r == S_FIND) ? idx_r[IDX_W-1:0] : wsum[IDX_W-1:0];
  end

  // shared comparator
  always_comb begin
    case (state_r)
      S_FIND:  cmp_b = key_r;
      S_SCAN:  cmp_b = have_start_r ? q_r : p_r;
      default: cmp_b = num_a_r;
    endcase
  end
  assign eq   = (rd_number == cmp_b);
  assign vcnt = idx_r - start_r + CNT_W'(1);

  always_comb begin
    wr.en     = accept && (in_data.mode == MODE_ADD) && (in_data.text_length != '0)
                && (in_data.text_length < 10'(TEXT_LIMIT));
    wr.addr   = wp_r;
    wr.number = in_data.block_number;
    wr.handle = in_data.text_handle;
  end

  nbrh_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_number (rd_number),
    .rd_handle (rd_handle)
  );

  // result for the current cycle
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '{status: ST_OK, hit: 1'b0, out_block_number: '0,
                      out_text_handle: '0, last_item: 1'b1,
                      evicted_flag: evict_r, visited_count: '0};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_ADD: begin
              out_valid_nxt = 1'b1;
              if (in_data.text_length == '0) begin
                out_nxt.status = ST_EMPTY;
              end else if (in_data.text_length >= 10'(TEXT_LIMIT)) begin
                out_nxt.status = ST_TOO_LONG;
              end else if (full) begin
                out_nxt.evicted_flag = 1'b1;
              end
            end
            MODE_FIND: ;
            MODE_RANGE: begin
              if (in_data.range_last < in_data.range_first) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_AMBIGUOUS;
              end
            end
            default: begin
              out_valid_nxt        = 1'b1;
              out_nxt.evicted_flag = 1'b0;
            end
          endcase
        end
      end
      S_FIND: begin
        if (idx_r == count_r) begin
          out_valid_nxt = 1'b1;
        end else if (eq) begin
          out_valid_nxt            = 1'b1;
          out_nxt.hit              = 1'b1;
          out_nxt.out_block_number = rd_number;
          out_nxt.out_text_handle  = rd_handle;
        end
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = ST_MISSING;
        end
      end
      S_DUPB: begin
        if (eq) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = ST_AMBIGUOUS;
        end
      end
      S_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_nxt.out_block_number = rd_number;
        out_nxt.out_text_handle  = rd_handle;
        out_nxt.last_item        = (idx_r == end_r);
        out_nxt.visited_count    = 5'(vcnt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      count_r      <= '0;
      evict_r      <= 1'b0;
      have_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r        <= in_data.block_number;
            p_r          <= in_data.range_first;
            q_r          <= in_data.range_last;
            idx_r        <= '0;
            have_start_r <= 1'b0;
            case (in_data.mode)
              MODE_ADD: begin
                if (wr.en) begin
                  if (full) begin
                    evict_r <= 1'b1;
                  end else begin
                    count_r <= count_r + CNT_W'(1);
                  end
                  wp_r <= (wp_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + IDX_W'(1);
                end
              end
              MODE_FIND: state_r <= S_FIND;
              MODE_RANGE: begin
                if (in_data.range_last >= in_data.range_first) begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
                wp_r    <= '0;
                count_r <= '0;
                evict_r <= 1'b0;
              end
            endcase
          end
        end
        S_FIND: begin
          if ((idx_r == count_r) || eq) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (idx_r == count_r) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
            if (eq && !have_start_r) begin
              have_start_r <= 1'b1;
              start_r      <= idx_r;
            end else if (eq) begin
              end_r   <= idx_r;
              a_r     <= start_r;
              state_r <= S_DUPA;
            end
          end
        end
        S_DUPA: begin
          if (a_r == end_r) begin
            idx_r   <= start_r;
            state_r <= S_EMIT;
          end else begin
            num_a_r <= rd_number;
            b_r     <= a_r + CNT_W'(1);
            state_r <= S_DUPB;
          end
        end
        S_DUPB: begin
          if (eq) begin
            state_r <= S_IDLE;
          end else if (b_r == end_r) begin
            a_r     <= a_r + CNT_W'(1);
            state_r <= S_DUPA;
          end else begin
            b_r <= b_r + CNT_W'(1);
          end
        end
        S_EMIT: begin
          idx_r <= idx_r + CNT_W'(1);
          if (idx_r == end_r) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HISTORY_DEPTH)) else $error("entry count overflow");
  a_wp_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (CNT_W'(wp_r) == count_r)) else $error("write pointer off count");
  a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid)) else $error("request dropped");
  a_visit_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_item |=> out_valid) else $error("visit gap");
`endif

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the numbered block ring history unit: a directed table of requests
// covering rejects, eviction, find and range corner cases, then random
// bursts of adds and lookups compared against an in-bench ring model
// ----------------------------------------------------------------------------
module tb_top;
  import nbrh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  numbered_block_ring_history_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ring model
  logic [31:0] ring_num [HISTORY_DEPTH];
  logic [15:0] ring_hdl [HISTORY_DEPTH];
  logic        ring_used [HISTORY_DEPTH];
  int          wr_ptr;
  int          fill;
  logic        evicted;

  out_t pending_results[$];
  int   errors = 0;
  int   results_seen = 0;
  int   requests_sent = 0;
  int   cycles = 0;
  int   visits_ok = 0;
  localparam int CYCLE_LIMIT = 400000;

  function automatic void ring_clear();
    for (int i = 0; i < HISTORY_DEPTH; i++) ring_used[i] = 1'b0;
    wr_ptr = 0;
    fill = 0;
    evicted = 1'b0;
  endfunction

  function automatic int slot_at(int pos);
    if (fill < HISTORY_DEPTH) return pos % HISTORY_DEPTH;
    return (wr_ptr + pos) % HISTORY_DEPTH;
  endfunction

  function automatic out_t single(logic [2:0] st, logic h, logic [31:0] n,
                                  logic [15:0] hd);
    out_t r;
    r = '0;
    r.status = st;
    r.hit = h;
    r.out_block_number = n;
    r.out_text_handle = hd;
    r.last_item = 1'b1;
    r.evicted_flag = evicted;
    return r;
  endfunction

  // applies one request to the ring model and queues its results
  function automatic void predict_history(in_t req);
    int p_pos, q_pos, total, k, s;
    bit have_p, have_q, dup;
    out_t r;
    p_pos = 0; q_pos = 0; total = 0; k = 0;
    have_p = 0; have_q = 0; dup = 0;
    case (req.mode)
      MODE_ADD: begin
        if (req.text_length == 0) pending_results.push_back(single(ST_EMPTY, 0, 0, 0));
        else if (req.text_length >= TEXT_LIMIT)
          pending_results.push_back(single(ST_TOO_LONG, 0, 0, 0));
        else begin
          if (ring_used[wr_ptr]) evicted = 1'b1;
          else if (fill < HISTORY_DEPTH) fill++;
          ring_num[wr_ptr] = req.block_number;
          ring_hdl[wr_ptr] = req.text_handle;
          ring_used[wr_ptr] = 1'b1;
          wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
          pending_results.push_back(single(ST_OK, 0, 0, 0));
        end
      end
      MODE_FIND: begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
          if (!have_p && ring_used[i] && ring_num[i] == req.block_number) begin
            have_p = 1;
            s = i;
          end
        if (have_p) pending_results.push_back(single(ST_OK, 1, ring_num[s], ring_hdl[s]));
        else pending_results.push_back(single(ST_OK, 0, 0, 0));
      end
      MODE_CLEAR: begin
        ring_clear();
        pending_results.push_back(single(ST_OK, 0, 0, 0));
      end
      default: begin
        if (req.range_last < req.range_first) begin
          pending_results.push_back(single(ST_AMBIGUOUS, 0, 0, 0));
          return;
        end
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          s = slot_at(i);
          if (ring_used[s]) begin
            if (!have_p) begin
              if (ring_num[s] == req.range_first) begin have_p = 1; p_pos = i; end
            end else if (!have_q && ring_num[s] == req.range_last) begin
              have_q = 1;
              q_pos = i;
            end
          end
        end
        if (!have_p || !have_q) begin
          pending_results.push_back(single(ST_MISSING, 0, 0, 0));
          return;
        end
        for (int i = p_pos; i <= q_pos; i++)
          for (int j = i + 1; j <= q_pos; j++)
            if (ring_used[slot_at(i)] && ring_used[slot_at(j)] &&
                ring_num[slot_at(i)] == ring_num[slot_at(j)]) dup = 1;
        if (dup) begin
          pending_results.push_back(single(ST_AMBIGUOUS, 0, 0, 0));
          return;
        end
        for (int i = p_pos; i <= q_pos; i++) if (ring_used[slot_at(i)]) total++;
        visits_ok++;
        for (int i = p_pos; i <= q_pos; i++) begin
          s = slot_at(i);
          if (ring_used[s]) begin
            k++;
            r = single(ST_OK, 0, ring_num[s], ring_hdl[s]);
            r.last_item = (k == total);
            r.visited_count = k[4:0];
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch @%0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  // result checking; the receiver cannot stall so every strobe is taken
  always @(posedge clk) begin
    out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) report_mismatch("unexpected result", out_data, 0);
      else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) report_mismatch("status", out_data.status, e.status);
        if (out_data.hit !== e.hit) report_mismatch("hit", out_data.hit, e.hit);
        if (out_data.out_block_number !== e.out_block_number)
          report_mismatch("block number", out_data.out_block_number, e.out_block_number);
        if (out_data.out_text_handle !== e.out_text_handle)
          report_mismatch("text handle", out_data.out_text_handle, e.out_text_handle);
        if (out_data.last_item !== e.last_item)
          report_mismatch("last item", out_data.last_item, e.last_item);
        if (out_data.evicted_flag !== e.evicted_flag)
          report_mismatch("evicted flag", out_data.evicted_flag, e.evicted_flag);
        if (out_data.visited_count !== e.visited_count)
          report_mismatch("visited count", out_data.visited_count, e.visited_count);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // sends one request; start stays high until accepted and is dropped by the caller
  task automatic send_request(in_t req);
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_history(req);
    requests_sent++;
  endtask

  function automatic in_t make_req(logic [1:0] m, logic [31:0] n, logic [15:0] h,
                                   logic [9:0] len, logic [31:0] p, logic [31:0] q);
    in_t r;
    r.mode = m; r.block_number = n; r.text_handle = h;
    r.text_length = len; r.range_first = p; r.range_last = q;
    return r;
  endfunction

  // small pool of numbers so finds and ranges hit often
  function automatic logic [31:0] pick_number();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    if (sel == 1) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    return $urandom_range(0, 23);
  endfunction

  typedef struct {
    in_t  req;
    bit   fixed;
    out_t want;
  } step_t;

  step_t steps[$];

  initial begin
    in_t r;
    int burst;
    int sent_random;
    out_t w;
    ring_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: fixed rows carry a typed-in result
    w = '0; w.last_item = 1'b1;
    steps.push_back('{make_req(MODE_FIND, 32'd5, 0, 0, 0, 0), 1, w});
    steps.push_back('{make_req(MODE_RANGE, 0, 0, 0, 32'd1, 32'd2), 0, w});
    steps.push_back('{make_req(MODE_RANGE, 0, 0, 0, 32'd9, 32'd3), 0, w});
    steps.push_back('{make_req(MODE_ADD, 32'd1, 16'hFFFF, 10'd0, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_ADD, 32'd1, 16'hFFFF, 10'd64, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_ADD, 32'd1, 16'hFFFF, 10'h3FF, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 10'd63, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_ADD, 32'd0, 16'h0000, 10'd1, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_RANGE, 0, 0, 0, 32'd7, 32'd7), 0, w});
    steps.push_back('{make_req(MODE_FIND, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, w});
    for (int i = 1; i <= 8; i++)
      steps.push_back('{make_req(MODE_ADD, 32'(i), 16'(i * 'h1111), 10'd10, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_RANGE, 0, 0, 0, 32'd0, 32'd8), 0, w});
    steps.push_back('{make_req(MODE_RANGE, 0, 0, 0, 32'd2, 32'd2), 0, w});
    for (int i = 9; i <= 15; i++)
      steps.push_back('{make_req(MODE_ADD, 32'(i), 16'(i), 10'd5, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_RANGE, 0, 0, 0, 32'd1, 32'd5), 0, w});
    steps.push_back('{make_req(MODE_FIND, 32'd3, 0, 0, 0, 0), 0, w});
    steps.push_back('{make_req(MODE_CLEAR, 0, 0, 0, 0, 0), 1, w});

    foreach (steps[i]) begin
      send_request(steps[i].req);
      if (steps[i].fixed && pending_results[$] !== steps[i].want)
        report_mismatch("directed row prediction", pending_results[$], steps[i].want);
    end

    // random bursts: mostly adds and lookups with real numbers
    sent_random = 0;
    while (sent_random < 190) begin
      burst = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        r.block_number = pick_number();
        r.text_handle = 16'($urandom());
        r.text_length = $urandom_range(0, 7) == 0 ? 10'($urandom())
                                                  : 10'($urandom_range(1, 63));
        r.range_first = pick_number();
        r.range_last = $urandom_range(0, 2) == 0 ? pick_number()
                                                 : r.range_first + $urandom_range(0, 12);
        case ($urandom_range(0, 19))
          0: r.mode = MODE_CLEAR;
          1, 2, 3, 4, 5, 6, 7, 8: r.mode = MODE_ADD;
          9, 10, 11, 12: r.mode = MODE_FIND;
          default: r.mode = MODE_RANGE;
        endcase
        send_request(r);
        sent_random++;
      end
      if (sent_random > 100 && sent_random < 115) begin
        // hold off until the unit has drained
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (HISTORY_DEPTH * HISTORY_DEPTH + 40) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d successful range visits",
             requests_sent, results_seen, visits_ok);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
